@@ rtl/iv_table_current_limiter_macros.svh @@
// Assertion macros used by the checker of the I-V table current limiter.
`ifndef IV_TABLE_CURRENT_LIMITER_MACROS_SVH
`define IV_TABLE_CURRENT_LIMITER_MACROS_SVH

// check a consequence in the same cycle
`define IVCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ivcl check failed");

// check a consequence in the next cycle
`define IVCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ivcl check failed");

`endif

@@ rtl/ivcl_pkg.sv @@
// Types and constants shared by the I-V table current limiter files.
`default_nettype none

package ivcl_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int PWR_GAIN       = 10000;
	localparam int PERMILLE       = 1000;
	localparam int PWR_SCALE      = PWR_GAIN / PERMILLE;
	localparam int PCT_FULL       = 100;
	localparam int PADDR_W        = 5;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_PROFILE = 3'd0,
		REG_COUNT   = 3'd1,
		REG_VMIN    = 3'd2,
		REG_VMAX    = 3'd3,
		REG_VTEST   = 3'd4,
		REG_POWER   = 3'd5,
		REG_TOL     = 3'd6,
		REG_HWMAX   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        func;
		logic [3:0]  point_index;
		logic [15:0] voltage;
		logic [15:0] cur_ma;
		logic [7:0]  req_pct;
	} in_item_t;

	typedef struct packed {
		logic [15:0] limit_ma;
		logic [6:0]  out_pct;
		logic        request_ok;
	} out_item_t;

	typedef struct packed {
		logic        profile_complete;
		logic [4:0]  point_count;
		logic [15:0] min_voltage;
		logic [15:0] max_voltage;
		logic [15:0] test_voltage;
		logic [11:0] rated_power;
		logic [9:0]  power_tolerance;
		logic [15:0] hw_max_current;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

@@ rtl/ivcl_regs.sv @@
// APB configuration register file of the I-V table current limiter.
`default_nettype none

module ivcl_regs import ivcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PROFILE: cfg_q.profile_complete <= pwdata[0];
				REG_COUNT:   cfg_q.point_count      <= pwdata[4:0];
				REG_VMIN:    cfg_q.min_voltage      <= pwdata[15:0];
				REG_VMAX:    cfg_q.max_voltage      <= pwdata[15:0];
				REG_VTEST:   cfg_q.test_voltage     <= pwdata[15:0];
				REG_POWER:   cfg_q.rated_power      <= pwdata[11:0];
				REG_TOL:     cfg_q.power_tolerance  <= pwdata[9:0];
				REG_HWMAX:   cfg_q.hw_max_current   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROFILE: prdata = 32'(cfg_q.profile_complete);
			REG_COUNT:   prdata = 32'(cfg_q.point_count);
			REG_VMIN:    prdata = 32'(cfg_q.min_voltage);
			REG_VMAX:    prdata = 32'(cfg_q.max_voltage);
			REG_VTEST:   prdata = 32'(cfg_q.test_voltage);
			REG_POWER:   prdata = 32'(cfg_q.rated_power);
			REG_TOL:     prdata = 32'(cfg_q.power_tolerance);
			REG_HWMAX:   prdata = 32'(cfg_q.hw_max_current);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ivcl_div.sv @@
// Shared restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`default_nettype none

module ivcl_div import ivcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] quotient
);

	localparam int DW    = 32;
	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    quo_q;
	logic [15:0]      rem_q;
	logic [15:0]      dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [16:0]      rem_sh;
	logic [16:0]      rem_sub;
	logic             fits;

	assign rem_sh   = {rem_q, quo_q[DW-1]};
	assign rem_sub  = rem_sh - {1'b0, dsr_q};
	assign fits     = rem_sh >= {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/ivcl_table.sv @@
// Point memory of the I-V table: one write port, one registered read port.
`default_nettype none

module ivcl_table import ivcl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_POINTS)-1:0] waddr,
	input  logic [31:0]                   wdata,
	input  logic [$clog2(MAX_POINTS)-1:0] raddr,
	output logic [31:0]                   rdata
);

	logic [31:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/iv_table_current_limiter.sv @@
// Top level of the I-V table current limiter: sequencer, shared multiplier and datapath.
`default_nettype none

// A write transaction stores one voltage/current point and offers an all-zero result in the
// next cycle. A query walks the point table one entry per cycle through the registered memory
// read port, then runs up to three divisions (interpolation, power clamp, safe percent) on one
// shared 32-step restoring divider, each preceded by a pass through the shared 32x16
// multiplier. A query that fails the profile, range and test-voltage checks skips the table
// walk and the divisions. in_ready is high only while the block is idle; the result waits in
// the output register until taken. Configuration writes go through the APB port at byte
// address 4*index; the user must write them only while idle; the block does not enforce it.
module iv_table_current_limiter import ivcl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FIRST = 9'b000000010,
		S_WALK  = 9'b000000100,
		S_MUL   = 9'b000001000,
		S_START = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_CLAMP = 9'b001000000,
		S_PCT   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		JOB_INTERP = 2'd0,
		JOB_POWER  = 2'd1,
		JOB_PCT    = 2'd2
	} job_t;

	cfg_t             cfg;
	state_t           state_q;
	state_t           state_d;
	job_t             job_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] cnt_nx;
	logic [15:0]      v_q;
	logic [15:0]      cur_q;
	logic [7:0]       req_q;
	logic [15:0]      lv_q;
	logic [15:0]      lc_q;
	logic [15:0]      t_q;
	logic [31:0]      opa_q;
	logic [15:0]      opb_q;
	logic [15:0]      dsr_q;
	logic [31:0]      prod_q;
	out_item_t        res_q;
	logic [47:0]      mul_full;
	logic             acc_in;
	logic             is_wr;
	logic             gate;
	logic             walk_end;
	logic             walk_over;
	logic             req_ok;
	logic [15:0]      pt_v;
	logic [15:0]      pt_c;
	logic             tbl_we;
	logic [ADDR_W-1:0] tbl_waddr;
	logic [ADDR_W-1:0] tbl_raddr;
	logic [31:0]      tbl_rdata;
	div_req_t         div_req;
	logic             div_done;
	logic [31:0]      div_quo;
	logic [15:0]      pwr_fac;
	logic [15:0]      pc_min;
	logic [6:0]       pct_cap;

	ivcl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ivcl_table #(.MAX_POINTS(MAX_POINTS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata ({in_data.voltage, in_data.cur_ma}),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ivcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	assign acc_in = in_valid & in_ready;
	assign is_wr  = (in_data.func == FUNC_WRITE);
	assign gate   = cfg.profile_complete && (cfg.point_count != '0)
		&& (in_data.voltage >= cfg.min_voltage) && (in_data.voltage <= cfg.max_voltage)
		&& (in_data.voltage != cfg.test_voltage);

	assign tbl_we    = acc_in && is_wr && (32'(in_data.point_index) < 32'(MAX_POINTS));
	assign tbl_waddr = ADDR_W'(in_data.point_index);
	assign cnt_nx    = cnt_q + CNT_W'(1);
	assign tbl_raddr = (state_q == S_IDLE) ? '0 : cnt_nx[ADDR_W-1:0];

	assign pt_v      = tbl_rdata[31:16];
	assign pt_c      = tbl_rdata[15:0];
	assign walk_end  = CMP_W'(cnt_q) >= CMP_W'(cfg.point_count);
	assign walk_over = (cnt_q == CNT_W'(MAX_POINTS));
	assign req_ok    = (req_q <= 8'(PCT_FULL)) && (cur_q != '0);

	assign mul_full = opa_q * opb_q;
	assign pwr_fac  = 16'(PWR_SCALE) * (16'(PERMILLE) + 16'(cfg.power_tolerance));

	assign div_req.start    = (state_q == S_START);
	assign div_req.dividend = prod_q + ((job_q == JOB_INTERP) ? 32'(dsr_q >> 1) : 32'd0);
	assign div_req.divisor  = dsr_q;

	assign pc_min  = (div_quo < 32'(t_q)) ? div_quo[15:0] : t_q;
	assign pct_cap = (div_quo > 32'(PCT_FULL)) ? 7'(PCT_FULL) : div_quo[6:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					cnt_d = '0;
					if (is_wr) begin
						state_d = S_OUT;
					end else if (gate) begin
						state_d = S_FIRST;
					end else begin
						state_d = S_PCT;
					end
				end
			end
			S_FIRST: begin
				if (v_q < pt_v) begin
					state_d = S_PCT;
				end else if (v_q == pt_v) begin
					state_d = S_CLAMP;
				end else begin
					cnt_d   = cnt_nx;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (walk_end) begin
					state_d = S_CLAMP;
				end else if (walk_over) begin
					state_d = S_PCT;
				end else if (v_q == pt_v) begin
					state_d = S_CLAMP;
				end else if (v_q < pt_v) begin
					state_d = S_MUL;
				end else begin
					cnt_d = cnt_nx;
				end
			end
			S_MUL:   state_d = S_START;
			S_START: state_d = S_DIV;
			S_DIV: begin
				if (div_done) begin
					case (job_q)
						JOB_INTERP: state_d = S_CLAMP;
						JOB_POWER:  state_d = S_PCT;
						JOB_PCT:    state_d = S_OUT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLAMP: state_d = ((t_q != '0) && (v_q != '0)) ? S_MUL : S_PCT;
			S_PCT:   state_d = (req_ok && (t_q != '0)) ? S_MUL : S_OUT;
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					v_q   <= in_data.voltage;
					cur_q <= in_data.cur_ma;
					req_q <= in_data.req_pct;
					t_q   <= '0;
					if (is_wr) begin
						res_q <= '0;
					end
				end
			end
			S_FIRST: begin
				lv_q <= pt_v;
				lc_q <= pt_c;
				if (v_q == pt_v) begin
					t_q <= pt_c;
				end
			end
			S_WALK: begin
				if (walk_end) begin
					t_q <= (v_q == lv_q) ? lc_q : '0;
				end else if (walk_over) begin
					t_q <= '0;
				end else if (v_q == pt_v) begin
					t_q <= pt_c;
				end else if (v_q < pt_v) begin
					job_q <= JOB_INTERP;
					opa_q <= 32'(lc_q) - 32'(pt_c);
					opb_q <= v_q - lv_q;
					dsr_q <= pt_v - lv_q;
				end else begin
					lv_q <= pt_v;
					lc_q <= pt_c;
				end
			end
			S_MUL: prod_q <= mul_full[31:0];
			S_DIV: begin
				if (div_done) begin
					case (job_q)
						JOB_INTERP: t_q <= lc_q - div_quo[15:0];
						JOB_POWER: begin
							t_q <= (pc_min > cfg.hw_max_current) ? cfg.hw_max_current : pc_min;
						end
						JOB_PCT: begin
							res_q.out_pct <= (8'(pct_cap) > req_q) ? req_q[6:0] : pct_cap;
						end
						default: ;
					endcase
				end
			end
			S_CLAMP: begin
				if ((t_q != '0) && (v_q != '0)) begin
					job_q <= JOB_POWER;
					opa_q <= 32'(cfg.rated_power);
					opb_q <= pwr_fac;
					dsr_q <= v_q;
				end else if (t_q > cfg.hw_max_current) begin
					t_q <= cfg.hw_max_current;
				end
			end
			S_PCT: begin
				res_q.limit_ma   <= t_q;
				res_q.request_ok <= req_ok;
				res_q.out_pct    <= '0;
				if (req_ok && (t_q != '0)) begin
					job_q <= JOB_PCT;
					opa_q <= 32'(t_q);
					opb_q <= 16'(PCT_FULL);
					dsr_q <= cur_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ivcl_checker.sv @@
// Port-level checker of the I-V table current limiter and its bind.
`default_nettype none
`include "iv_table_current_limiter_macros.svh"

module ivcl_checker import ivcl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic in_acc_wr;
	logic out_stall;
	logic out_bad;

	assign in_acc_wr = in_valid && in_ready && (in_data.func == FUNC_WRITE);
	assign out_stall = out_valid && !out_ready;
	assign out_bad   = out_valid && !out_data.request_ok;

	`IVCL_ASSERT_NEXT(a_write_result, clk, arst_n, in_acc_wr, out_valid && (out_data == '0))
	`IVCL_ASSERT_NOW(a_one_at_a_time, clk, arst_n, out_valid, !in_ready)
	`IVCL_ASSERT_NOW(a_pct_range, clk, arst_n, out_valid, out_data.out_pct <= 7'(PCT_FULL))
	`IVCL_ASSERT_NOW(a_bad_req_zero, clk, arst_n, out_bad, out_data.out_pct == '0)
	`IVCL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))

endmodule

bind iv_table_current_limiter ivcl_checker u_ivcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
